FILE: sv/msr_pkg.sv
package msr_pkg;

  // Default sizing of the residue tables and the arithmetic.
  localparam int MODULUS_DEF    = 109;
  localparam int VALUE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 40;

  // Fixed payload widths on the channels, and the widened best-sum width.
  localparam int VALUE_W = 16;
  localparam int BEST_W  = 40;
  localparam int EXT_W   = 64;

  // Status of the shared residue unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

FILE: sv/msr_grp_if.sv
interface msr_grp_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::VALUE_W-1:0] value_a;
  logic [msr_pkg::VALUE_W-1:0] value_b;
  logic [msr_pkg::VALUE_W-1:0] value_c;
  logic                        first_group;
  logic                        last_group;

  modport source (
    output valid, value_a, value_b, value_c, first_group, last_group,
    input  ready
  );

  modport sink (
    input  valid, value_a, value_b, value_c, first_group, last_group,
    output ready
  );
endinterface

FILE: sv/msr_res_if.sv
interface msr_res_if;
  logic                       valid;
  logic                       ready;
  logic [msr_pkg::BEST_W-1:0] best_sum;
  logic                       found;

  modport source (
    output valid, best_sum, found,
    input  ready
  );

  modport sink (
    input  valid, best_sum, found,
    output ready
  );
endinterface

FILE: sv/msr_mod_unit.sv
module msr_mod_unit #(
  parameter  int MODULUS    = msr_pkg::MODULUS_DEF,
  parameter  int VALUE_BITS = msr_pkg::VALUE_BITS_DEF,
  localparam int RB         = $clog2(MODULUS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output msr_pkg::mod_stat_t    stat,
  output logic [RB-1:0]         residue
);

  localparam int            RW      = VALUE_BITS + 2;
  localparam int            PW      = VALUE_BITS + RW;
  localparam int            QW      = VALUE_BITS + 9;
  localparam int            SHIFT   = VALUE_BITS + RB;
  localparam logic [63:0]   POW     = 64'd1 << SHIFT;
  localparam logic [63:0]   RECIP64 = (POW + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
  localparam logic [RW-1:0] RECIP   = RW'(RECIP64);

  logic [VALUE_BITS-1:0] held;
  logic [VALUE_BITS-1:0] quo;
  logic [RB-1:0]         rem;
  logic                  busy;
  logic                  done;
  logic                  step;
  logic [PW-1:0]         prod;
  logic [QW-1:0]         back;
  logic [QW-1:0]         diff;

  // Quotient by a rounded-up reciprocal, exact for every VALUE_BITS-bit
  // input; then take the remainder back off the value.
  always_comb begin
    prod = PW'(held) * PW'(RECIP);
    back = QW'(quo) * QW'(MODULUS);
    diff = QW'(held) - back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        held <= value;
        step <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!step) begin
          quo  <= VALUE_BITS'(prod >> SHIFT);
          step <= 1'b1;
        end else begin
          rem  <= RB'(diff);
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign residue   = rem;

endmodule

FILE: sv/msr_bank_mem.sv
module msr_bank_mem #(
  parameter int AW = 8,
  parameter int DW = msr_pkg::SUM_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [DW-1:0] rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/max_sum_residue_dp.sv
// max_sum_residue_dp: largest sum over one-of-three choices per group whose
// residue modulo MODULUS is not zero.
//
// Channels: grp takes one group per beat (three candidate values plus the
// first_group / last_group marks); res gives one beat (best_sum, found) after
// each group marked last. found = 0 means no selection reaches a nonzero
// residue, and best_sum is then 0.
//
// Per group: an accept, then the shared residue unit for each value in turn
// (reciprocal multiply, multiply-subtract, done), then a sweep through the
// table memory for each value (one residue per cycle, read-modify-write into
// the other bank over a pipe), then a drain. A last group adds a scan of
// the nonzero residues. grp.ready is high only between groups.
//
// Reset clears every valid mark and selects bank 0; table data is not
// cleared. A result waits in the output register while res.ready is low and
// the next group is still taken; a second result holds until the first beat
// has gone.
module max_sum_residue_dp #(
  parameter int MODULUS    = msr_pkg::MODULUS_DEF,
  parameter int VALUE_BITS = msr_pkg::VALUE_BITS_DEF,
  parameter int SUM_BITS   = msr_pkg::SUM_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  msr_grp_if.sink  grp,
  msr_res_if.source res
);

  localparam int RB = $clog2(MODULUS);
  localparam int AW = RB + 1;
  localparam int XW = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
  localparam logic [SUM_BITS-1:0] SUM_LIMIT = '1;
  localparam logic [RB-1:0]       LIMIT_RES = RB'(SUM_LIMIT % MODULUS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MOD    = 6'b000010,
    ST_SWEEP  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  logic   bank;
  logic   dbank;
  logic [MODULUS-1:0] valid_q [2];

  // Latched group.
  logic [VALUE_BITS-1:0] val_a, val_b, val_c;
  logic [VALUE_BITS-1:0] a_m, b_m, c_m;
  logic                  first_q, last_q;
  logic [RB-1:0]         vres_a, vres_b, vres_c;

  // Sequencer counters.
  logic [1:0]    j;
  logic [RB-1:0] r;

  // Shared residue unit.
  logic                  mod_start;
  logic [VALUE_BITS-1:0] mod_value;
  msr_pkg::mod_stat_t    mod_stat;
  logic [RB-1:0]         mod_res;

  // Table memory.
  logic [AW-1:0]       mem_waddr;
  logic [SUM_BITS-1:0] rd_a, rd_b;

  // Sweep pipe.
  logic                s1_go;
  logic [1:0]          s1_j;
  logic [RB-1:0]       s1_r;
  logic [SUM_BITS-1:0] s1_base;
  logic [VALUE_BITS-1:0] s1_v;
  logic [RB-1:0]       s1_vres;
  logic [XW-1:0]       s1_sum;
  logic                s1_sat;
  logic [SUM_BITS-1:0] s1_t;
  logic [RB:0]         s1_rk;
  logic [RB-1:0]       s1_k;
  logic                s2_go;
  logic [SUM_BITS-1:0] s2_t;
  logic [RB-1:0]       s2_k;
  logic [SUM_BITS-1:0] s2_old;
  logic                s2_has;
  logic                s2_we;
  logic                p_we;
  logic [RB-1:0]       p_k;
  logic [SUM_BITS-1:0] p_t;

  // Final scan.
  logic                sc_go, sc_vld;
  logic                any;
  logic [SUM_BITS-1:0] best;
  logic [msr_pkg::EXT_W-1:0] best_ext;

  logic grp_acc;
  logic res_load;

  assign dbank      = ~bank;
  assign grp.ready  = (state == ST_IDLE);
  assign grp_acc    = grp.valid && grp.ready;
  assign res_load   = (state == ST_FINISH) && !sc_go && (!res.valid || res.ready);

  assign a_m = VALUE_BITS'(32'(grp.value_a));
  assign b_m = VALUE_BITS'(32'(grp.value_b));
  assign c_m = VALUE_BITS'(32'(grp.value_c));

  // Feed the residue unit: value a at accept, then b and c as each finishes.
  assign mod_start = grp_acc || ((state == ST_MOD) && mod_stat.done && (j != 2'd2));
  assign mod_value = (state == ST_IDLE) ? a_m : ((j == 2'd0) ? val_b : val_c);

  msr_mod_unit #(
    .MODULUS    (MODULUS),
    .VALUE_BITS (VALUE_BITS)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (mod_value),
    .stat    (mod_stat),
    .residue (mod_res)
  );

  assign mem_waddr = {dbank, s2_k};

  msr_bank_mem #(
    .AW (AW),
    .DW (SUM_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (s2_we),
    .waddr   (mem_waddr),
    .wdata   (s2_t),
    .raddr_a ({bank, r}),
    .rdata_a (rd_a),
    .raddr_b ({dbank, s1_k}),
    .rdata_b (rd_b)
  );

  // Stage 1: extend the source sum by the candidate, saturate, find its
  // residue from the source residue plus the value residue.
  always_comb begin
    case (s1_j)
      2'd0:    begin s1_v = val_a; s1_vres = vres_a; end
      2'd1:    begin s1_v = val_b; s1_vres = vres_b; end
      default: begin s1_v = val_c; s1_vres = vres_c; end
    endcase
    s1_base = first_q ? '0 : rd_a;
    s1_sum  = XW'(s1_base) + XW'(s1_v);
    s1_sat  = s1_sum > XW'(SUM_LIMIT);
    s1_t    = s1_sat ? SUM_LIMIT : s1_sum[SUM_BITS-1:0];
    s1_rk   = (RB+1)'(s1_r) + (RB+1)'(s1_vres);
    if (s1_rk >= (RB+1)'(MODULUS)) begin
      s1_rk = s1_rk - (RB+1)'(MODULUS);
    end
    s1_k = s1_sat ? LIMIT_RES : s1_rk[RB-1:0];
  end

  // Stage 2: compare against the destination entry. The write of the
  // previous cycle is not yet in the read data, so forward it.
  always_comb begin
    s2_old = (p_we && (p_k == s2_k)) ? p_t : rd_b;
    s2_has = valid_q[dbank][s2_k];
    s2_we  = s2_go && (!s2_has || (s2_old < s2_t));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_go <= 1'b0;
      s2_go <= 1'b0;
      p_we  <= 1'b0;
      sc_go <= 1'b0;
    end else begin
      s1_go <= (state == ST_SWEEP) && (first_q ? (r == '0) : valid_q[bank][r]);
      s2_go <= s1_go;
      p_we  <= s2_we;
      sc_go <= (state == ST_SCAN);
    end
    s1_j   <= j;
    s1_r   <= r;
    s2_t   <= s1_t;
    s2_k   <= s1_k;
    p_k    <= s2_k;
    p_t    <= s2_t;
    sc_vld <= valid_q[bank][r];
  end

  // Valid marks: drop the destination bank at accept, set on every write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= '0;
      valid_q[1] <= '0;
    end else begin
      if (grp_acc) begin
        valid_q[dbank] <= '0;
      end
      if (s2_we) begin
        valid_q[dbank][s2_k] <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bank  <= 1'b0;
      j     <= '0;
      r     <= '0;
      any   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (grp_acc) begin
            val_a   <= a_m;
            val_b   <= b_m;
            val_c   <= c_m;
            first_q <= grp.first_group;
            last_q  <= grp.last_group;
            j       <= '0;
            any     <= 1'b0;
            state   <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_stat.done) begin
            case (j)
              2'd0:    vres_a <= mod_res;
              2'd1:    vres_b <= mod_res;
              default: vres_c <= mod_res;
            endcase
            if (j == 2'd2) begin
              j     <= '0;
              r     <= '0;
              state <= ST_SWEEP;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        ST_SWEEP: begin
          if (r == RB'(MODULUS - 1)) begin
            r <= '0;
            if (j == 2'd2) begin
              state <= ST_DRAIN;
            end else begin
              j <= j + 2'd1;
            end
          end else begin
            r <= r + RB'(1);
          end
        end
        ST_DRAIN: begin
          // Flip banks once the last write has landed.
          if (!s1_go && !s2_go) begin
            bank <= ~bank;
            if (last_q) begin
              r     <= RB'(1);
              state <= ST_SCAN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (r == RB'(MODULUS - 1)) begin
            state <= ST_FINISH;
          end else begin
            r <= r + RB'(1);
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Keep the running maximum over the nonzero residues.
      if (sc_go && sc_vld && (!any || (rd_a > best))) begin
        any <= 1'b1;
      end
    end
    if (sc_go && sc_vld && (!any || (rd_a > best))) begin
      best <= rd_a;
    end
  end

  // Output register: hold the beat until taken.
  assign best_ext = msr_pkg::EXT_W'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (res_load) begin
      res.found    <= any;
      res.best_sum <= any ? best_ext[msr_pkg::BEST_W-1:0] : '0;
    end
  end

`ifndef ASSERT_OFF
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    grp.ready |-> (!s1_go && !s2_go && !sc_go))
    else $error("sweep pipe busy while taking a group");

  a_write_dst_bank: assert property (@(posedge clk) disable iff (rst)
    s2_we |-> (mem_waddr[AW-1] != bank))
    else $error("table write into the source bank");

  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    s2_go |-> (s2_k < RB'(MODULUS - 1)) || (s2_k == RB'(MODULUS - 1)))
    else $error("destination residue out of range");

  a_mod_busy_state: assert property (@(posedge clk) disable iff (rst)
    mod_stat.busy |-> (state == ST_MOD))
    else $error("residue unit running outside its phase");
`endif

endmodule

FILE: tb/msr_tb_pkg.sv
package msr_tb_pkg;

  localparam int MOD     = msr_pkg::MODULUS_DEF;
  localparam int SUM_W   = msr_pkg::SUM_BITS_DEF;
  localparam int VALUE_W = msr_pkg::VALUE_W;
  localparam int BEST_W  = msr_pkg::BEST_W;
  localparam logic [64:0] SUM_MAX = (65'd1 << SUM_W) - 1;
  localparam logic [63:0] VALUE_MASK = (64'd1 << msr_pkg::VALUE_BITS_DEF) - 1;

  typedef struct packed {
    logic [BEST_W-1:0] best_sum;
    logic              found;
  } best_beat_t;

  // Track the best sum per residue of the current set and queue the
  // (best_sum, found) beat owed after each group marked last.
  class best_sum_board;
    logic [SUM_W-1:0] best_by_res[MOD];
    bit               reach_by_res[MOD];
    best_beat_t       owed_beats[$];
    int               errors;
    int               reports;
    int               empty_reports;
    int               groups;

    function new();
      errors        = 0;
      reports       = 0;
      empty_reports = 0;
      groups        = 0;
      for (int r = 0; r < MOD; r++) begin
        reach_by_res[r] = 1'b0;
        best_by_res[r]  = '0;
      end
    endfunction

    function void apply_group(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                              logic [VALUE_W-1:0] c, logic first, logic last);
      logic [SUM_W-1:0] next_best[MOD];
      bit               next_reach[MOD];
      logic [63:0]      cand[3];
      logic [64:0]      sum_wide;
      logic [SUM_W-1:0] base;
      logic [SUM_W-1:0] total;
      int               k;
      best_beat_t       beat;
      cand[0] = 64'(a) & VALUE_MASK;
      cand[1] = 64'(b) & VALUE_MASK;
      cand[2] = 64'(c) & VALUE_MASK;
      groups++;
      for (int r = 0; r < MOD; r++) begin
        next_reach[r] = 1'b0;
        next_best[r]  = '0;
      end
      for (int j = 0; j < 3; j++) begin
        for (int r = 0; r < MOD; r++) begin
          // A first group starts from the empty selection alone.
          if (first) begin
            if (r != 0) continue;
            base = '0;
          end else begin
            if (!reach_by_res[r]) continue;
            base = best_by_res[r];
          end
          sum_wide = 65'(base) + 65'(cand[j]);
          total    = (sum_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_wide[SUM_W-1:0];
          k        = int'(64'(total) % 64'(MOD));
          if (!next_reach[k] || next_best[k] < total) begin
            next_best[k]  = total;
            next_reach[k] = 1'b1;
          end
        end
      end
      best_by_res  = next_best;
      reach_by_res = next_reach;
      if (last) begin
        beat = '0;
        for (int r = 1; r < MOD; r++) begin
          if (reach_by_res[r] && (!beat.found || 64'(best_by_res[r]) > 64'(beat.best_sum))) begin
            beat.best_sum = BEST_W'(best_by_res[r]);
            beat.found    = 1'b1;
          end
        end
        owed_beats = {owed_beats, beat};
      end
    endfunction

    function void check_result(logic [BEST_W-1:0] best_sum, logic found);
      best_beat_t want;
      if (owed_beats.size() == 0) begin
        $display("%0t: result with nothing owed: best_sum=%0d found=%0b",
                 $time, best_sum, found);
        errors++;
        return;
      end
      want = owed_beats.pop_front();
      reports++;
      if (!want.found) empty_reports++;
      if (best_sum !== want.best_sum) begin
        $display("%0t: best_sum mismatch: expected %0d, actual %0d",
                 $time, want.best_sum, best_sum);
        errors++;
      end
      if (found !== want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, found);
        errors++;
      end
    endfunction

    function int owed();
      return owed_beats.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = msr_pkg::VALUE_W;
  localparam int MODULUS_DEF = msr_pkg::MODULUS_DEF;

  // Allow for the slowest group, the long hold-off and random stalls on top,
  // several times over.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int HOLD_CYCLES   = 3000;
  localparam int PHASE_ITEMS   = 400;
  localparam logic [VALUE_W-1:0] VMAX = '1;

  typedef enum int {VAL_ANY, VAL_SMALL, VAL_MOD_ZERO, VAL_EXTREME, VAL_MIXED} value_style_t;

  logic clk;
  logic rst;

  msr_grp_if grp_ch();
  msr_res_if res_ch();

  max_sum_residue_dp dut (
    .clk (clk),
    .rst (rst),
    .grp (grp_ch),
    .res (res_ch)
  );

  msr_tb_pkg::best_sum_board board;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int cycle_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Give up on a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("max_sum_residue_dp test failed");
      $finish;
    end
  end

  // Receiver: drop ready at random, or hold it low for a counted stretch
  // so the output register and the next result fill and grp stalls.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_off_cycles--;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check every result beat against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      board.check_result(res_ch.best_sum, res_ch.found);
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value(value_style_t style);
    value_style_t s;
    s = style;
    if (s == VAL_MIXED) s = value_style_t'($urandom_range(0, 3));
    case (s)
      VAL_SMALL:    return VALUE_W'($urandom_range(0, 250));
      VAL_MOD_ZERO: return VALUE_W'(MODULUS_DEF * $urandom_range(0, 601));
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return VMAX;
          2:       return VMAX - VALUE_W'($urandom_range(0, MODULUS_DEF - 1));
          default: return VALUE_W'($urandom_range(0, MODULUS_DEF - 1));
        endcase
      end
      default:      return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one group, entered and left at a falling edge. Idle gaps keep
  // valid low; a back-to-back group leaves valid high.
  task automatic send_group(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                            input logic [VALUE_W-1:0] c, input logic first,
                            input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      grp_ch.valid <= 1'b0;
      @(negedge clk);
    end
    grp_ch.valid       <= 1'b1;
    grp_ch.value_a     <= a;
    grp_ch.value_b     <= b;
    grp_ch.value_c     <= c;
    grp_ch.first_group <= first;
    grp_ch.last_group  <= last;
    @(posedge clk);
    while (!grp_ch.ready) @(posedge clk);
    board.apply_group(a, b, c, first, last);
    @(negedge clk);
  endtask

  task automatic send_set(input int len, input value_style_t style,
                          input logic opens, input logic closes);
    for (int i = 0; i < len; i++) begin
      send_group(pick_value(style), pick_value(style), pick_value(style),
                 opens && (i == 0), closes && (i == len - 1));
    end
  endtask

  // Mostly well-formed sets with random content; the rest continue a
  // reported set, leave a set open, or hit the extremes alone.
  task automatic run_random_sets(input int quota);
    int start_groups;
    int kind;
    int len;
    start_groups = board.groups;
    while (board.groups - start_groups < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        send_set(len, value_style_t'($urandom_range(0, 4)), 1'b1, 1'b1);
      end else if (kind < 90) begin
        send_set($urandom_range(1, 3), VAL_MIXED, 1'b0, 1'b1);
      end else if (kind < 95) begin
        send_set($urandom_range(1, 4), VAL_MIXED, 1'b1, 1'b0);
      end else begin
        send_set(1, VAL_EXTREME, 1'b1, 1'b1);
      end
    end
  endtask

  initial begin
    board            = new();
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_cycles  = 0;
    rst              = 1'b1;
    grp_ch.valid       = 1'b0;
    grp_ch.value_a     = '0;
    grp_ch.value_b     = '0;
    grp_ch.value_c     = '0;
    grp_ch.first_group = 1'b0;
    grp_ch.last_group  = 1'b0;
    res_ch.ready       = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    // No set started since reset: tables stay empty, found = 0.
    send_group(16'd5, 16'd7, 16'd9, 1'b0, 1'b0);
    send_group(VMAX, 16'd0, 16'd1, 1'b0, 1'b1);
    // First and last together, with all-zero and all-max values.
    send_group(16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
    send_group(VMAX, VMAX, VMAX, 1'b1, 1'b1);
    // Every candidate a multiple of the modulus: only residue zero reached.
    send_group(16'd109, 16'd218, 16'd65509, 1'b1, 1'b0);
    send_group(16'd0, 16'd327, 16'd436, 1'b0, 1'b1);
    // Shared residues: candidates that land on the same residue.
    send_group(16'd100, 16'd209, 16'd1, 1'b1, 1'b0);
    send_group(16'd9, 16'd118, 16'd0, 1'b0, 1'b1);
    // Continue the set just reported, without a new first group.
    send_group(16'd1, 16'd2, 16'd3, 1'b0, 1'b1);
    // Bit patterns on every field.
    send_group(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b0);
    send_group(16'h5555, 16'hAAAA, 16'h0000, 1'b0, 1'b0);
    send_group(16'h8000, 16'h0001, 16'h7FFF, 1'b0, 1'b1);
    // Open a set without closing it, then restart.
    send_group(16'd10, 16'd20, 16'd30, 1'b1, 1'b0);
    send_group(16'd40, 16'd50, 16'd60, 1'b1, 1'b1);
    // Longer set at the top of the value range.
    send_group(VMAX, 16'd0, 16'd32768, 1'b1, 1'b0);
    send_group(VMAX, VMAX - 16'd1, 16'd108, 1'b0, 1'b0);
    send_group(16'd0, 16'd1, VMAX, 1'b0, 1'b0);
    send_group(VMAX, VMAX, VMAX, 1'b0, 1'b1);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase == 0) begin
        // Hold results off long enough for the block to back up into grp.
        hold_off_cycles = HOLD_CYCLES;
        repeat (8) send_set(1, VAL_MIXED, 1'b1, 1'b1);
      end
      run_random_sets(PHASE_ITEMS);
    end

    // Close on a reported set, then let valid go.
    send_group(pick_value(VAL_ANY), pick_value(VAL_ANY), pick_value(VAL_ANY), 1'b1, 1'b1);
    grp_ch.valid <= 1'b0;

    while (board.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d groups and %0d result beats, %0d of them with no nonzero residue.",
             board.groups, board.reports, board.empty_reports);
    $display("Traffic went through no idling, sender gaps, receiver stalls, both, and a long hold-off.");
    if (board.errors == 0) begin
      $display("max_sum_residue_dp test passed");
    end else begin
      $display("max_sum_residue_dp test failed");
    end
    $finish;
  end

endmodule
